// File: rtl/rhl_pkg.sv
// Package for the RGB/HSV LED color driver: payload structs, command codes
// and sequencer constants. No dependencies.
package rhl_pkg;

  localparam logic [1:0] CMD_RGB     = 2'd0;
  localparam logic [1:0] CMD_HSV     = 2'd1;
  localparam logic [1:0] CMD_REAPPLY = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;  // unused code, acts as re-apply

  localparam logic [1:0] REG_MAX_LEVEL  = 2'd0;
  localparam logic [1:0] REG_LIGHTS_OFF = 2'd1;
  localparam logic [1:0] REG_SPARE      = 2'd3;  // no register behind it

  localparam int DvdW = 15;  // widest dividend: 100*255
  localparam int DsrW = 8;   // widest divisor: 255

  // Reciprocal multiply for the constant divisions: q = (x * R) >> RcpSh.
  // Exact truncation for every operand the sequencer produces.
  localparam int MulW  = 21;  // widest operand: 6000*255
  localparam int RcpW  = 26;
  localparam int RcpSh = 32;
  localparam logic [RcpW-1:0] RcpDiv100  = 26'd42949673;
  localparam logic [RcpW-1:0] RcpDiv255  = 26'd16843010;
  localparam logic [RcpW-1:0] RcpDiv6000 = 26'd715828;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [8:0] hue_in;
    logic [6:0] sat_in;
    logic [6:0] val_in;
  } in_t;

  typedef struct packed {
    logic [7:0] drive_red;
    logic [7:0] drive_green;
    logic [7:0] drive_blue;
    logic [8:0] hue_out;
    logic [6:0] sat_out;
    logic [6:0] val_out;
  } out_t;

endpackage

// File: rtl/rgb_hsv_led_color_driver.sv
// RGB/HSV LED color driver top level. Depends on rhl_pkg.
// Sequence: command 0 (RGB) runs two serial divisions and seven reciprocal
//   multiplies before the output register; other commands run only the render multiplies.
// Throughput: one item in flight; the next input is taken once the block is idle
//   again, after any stalled earlier result has left.
// Reset: async active-low; max_level=100, lights_off=0, stored HSV cleared.
module rgb_hsv_led_color_driver (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rhl_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rhl_pkg::out_t    out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [6:0]       cfg_data_i
);
  import rhl_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Op sequence; RGB conversion ops run first, then the render ops.
  // HUE and SAT divide by a variable and use the serial divider; the rest
  // divide by a constant and use the reciprocal multiplier.
  localparam logic [3:0] OP_HUE = 4'd0;
  localparam logic [3:0] OP_SAT = 4'd1;
  localparam logic [3:0] OP_VAL = 4'd2;
  localparam logic [3:0] OP_RV  = 4'd3;
  localparam logic [3:0] OP_RM  = 4'd4;
  localparam logic [3:0] OP_LV  = 4'd5;
  localparam logic [3:0] OP_LM  = 4'd6;
  localparam logic [3:0] OP_LI  = 4'd7;
  localparam logic [3:0] OP_LD  = 4'd8;

  logic [2:0] state_q, state_d;
  logic [3:0] op_q;
  logic [4:0] cnt_q;
  logic [6:0] max_level_q;
  logic       lights_off_q;
  logic [7:0] r_q, g_q, b_q;
  logic [8:0] hue_q;
  logic [6:0] sat_q, val_q;
  logic [6:0] v_q, m_q;
  logic [7:0] lvv_q, lmin_q, linc_q, ldec_q;
  logic [DvdW-1:0] dvd_q;
  logic [DsrW-1:0] rem_q, dsr_q;
  logic [MulW-1:0] mul_q;
  logic       out_valid_q;
  out_t       out_q;

  // ---- RGB max/min and hue terms ----
  logic       red_max, green_max;
  logic [7:0] mx, mn, dlt, hi_c, lo_c;
  always_comb begin
    red_max   = (r_q >= g_q) && (r_q >= b_q);
    green_max = !red_max && (g_q >= b_q);
    mx = red_max ? r_q : (green_max ? g_q : b_q);
    mn = r_q;
    if (g_q < mn) mn = g_q;
    if (b_q < mn) mn = b_q;
    dlt = mx - mn;
    // hue numerator is 60*(hi_c - lo_c)
    if (red_max) begin
      hi_c = g_q; lo_c = b_q;
    end else if (green_max) begin
      hi_c = b_q; lo_c = r_q;
    end else begin
      hi_c = r_q; lo_c = g_q;
    end
  end
  logic       hneg;
  logic [7:0] hmag;
  assign hneg = hi_c < lo_c;
  assign hmag = hneg ? (lo_c - hi_c) : (hi_c - lo_c);

  // ---- hue sector and offset ----
  logic [2:0] sector;
  logic [8:0] sec_base;
  always_comb begin
    if (hue_q >= 9'd300) begin
      sector = 3'd5; sec_base = 9'd300;
    end else if (hue_q >= 9'd240) begin
      sector = 3'd4; sec_base = 9'd240;
    end else if (hue_q >= 9'd180) begin
      sector = 3'd3; sec_base = 9'd180;
    end else if (hue_q >= 9'd120) begin
      sector = 3'd2; sec_base = 9'd120;
    end else if (hue_q >= 9'd60) begin
      sector = 3'd1; sec_base = 9'd60;
    end else begin
      sector = 3'd0; sec_base = 9'd0;
    end
  end
  logic [5:0]  frac;
  logic [12:0] vm_f, inc_n, dec_n;
  assign frac  = 6'(hue_q - sec_base);
  assign vm_f  = 13'(v_q - m_q) * 13'(frac);
  assign inc_n = 13'(m_q) * 13'd60 + vm_f;
  assign dec_n = 13'(v_q) * 13'd60 - vm_f;

  logic [6:0] ml_sat;
  assign ml_sat = (max_level_q > 7'd100) ? 7'd100 : max_level_q;

  // ---- divider operands ----
  logic [DvdW-1:0] ld_dvd;
  logic [DsrW-1:0] ld_dsr;
  always_comb begin
    case (op_q)
      OP_HUE: begin
        ld_dvd = DvdW'(hmag) * DvdW'(60);  ld_dsr = dlt;
      end
      OP_SAT: begin
        ld_dvd = DvdW'(mn) * DvdW'(100);   ld_dsr = mx;
      end
      default: begin
        ld_dvd = '0; ld_dsr = DsrW'(1);
      end
    endcase
  end

  // ---- reciprocal multiplier operand and constant ----
  logic [MulW-1:0] ld_mul;
  logic [RcpW-1:0] rcp;
  always_comb begin
    case (op_q)
      OP_VAL:  ld_mul = MulW'(mx) * MulW'(100);
      OP_RV:   ld_mul = MulW'(val_q) * MulW'(ml_sat);
      OP_RM:   ld_mul = MulW'(7'd100 - sat_q) * MulW'(v_q);
      OP_LV:   ld_mul = (MulW'(v_q) << 8) - MulW'(v_q);
      OP_LM:   ld_mul = (MulW'(m_q) << 8) - MulW'(m_q);
      OP_LI:   ld_mul = (MulW'(inc_n) << 8) - MulW'(inc_n);
      OP_LD:   ld_mul = (MulW'(dec_n) << 8) - MulW'(dec_n);
      default: ld_mul = '0;
    endcase
    case (op_q)
      OP_VAL:       rcp = RcpDiv255;
      OP_LI, OP_LD: rcp = RcpDiv6000;
      default:      rcp = RcpDiv100;
    endcase
  end

  logic [MulW+RcpW-1:0] mul_p;
  logic [7:0]           rq;
  assign mul_p = {{RcpW{1'b0}}, mul_q} * {{MulW{1'b0}}, rcp};
  assign rq    = mul_p[RcpSh +: 8];

  // ---- restoring divider step ----
  logic [DsrW:0]   trial;
  logic            qbit;
  logic [DsrW-1:0] rem_next;
  always_comb begin
    trial    = {rem_q, dvd_q[DvdW-1]};
    qbit     = trial >= {1'b0, dsr_q};
    rem_next = qbit ? DsrW'(trial - {1'b0, dsr_q}) : trial[DsrW-1:0];
  end
  logic [DvdW-1:0] quo;
  assign quo = {dvd_q[DvdW-2:0], qbit};  // quotient after the final step

  // hue from the quotient; a hue of 360 wraps to 0, a gray color has hue 0
  logic [8:0] hue_base, hue_raw, hue_fix;
  always_comb begin
    if (red_max)        hue_base = hneg ? 9'd360 : 9'd0;
    else if (green_max) hue_base = 9'd120;
    else                hue_base = 9'd240;
    hue_raw = hneg ? (hue_base - 9'(quo[6:0])) : (hue_base + 9'(quo[6:0]));
    hue_fix = (hue_raw >= 9'd360) ? (hue_raw - 9'd360) : hue_raw;
    if (dlt == 8'd0) hue_fix = 9'd0;
  end

  // ---- output mapping ----
  logic [7:0] lr, lg, lb;
  always_comb begin
    case (sector)
      3'd0:    begin lr = lvv_q;  lg = linc_q; lb = lmin_q; end
      3'd1:    begin lr = ldec_q; lg = lvv_q;  lb = lmin_q; end
      3'd2:    begin lr = lmin_q; lg = lvv_q;  lb = linc_q; end
      3'd3:    begin lr = lmin_q; lg = ldec_q; lb = lvv_q;  end
      3'd4:    begin lr = linc_q; lg = lmin_q; lb = lvv_q;  end
      default: begin lr = lvv_q;  lg = lmin_q; lb = ldec_q; end
    endcase
  end

  logic in_xfer, div_last, mul_step, op_var, out_free;
  assign in_xfer  = in_valid_i && (state_q == ST_IDLE);
  assign div_last = (state_q == ST_DIV) && (cnt_q == 5'd0);
  assign mul_step = (state_q == ST_MUL);
  assign op_var   = (op_q == OP_HUE) || (op_q == OP_SAT);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = op_var ? ST_DIV : ST_MUL;
      ST_DIV:  if (cnt_q == 5'd0) state_d = ST_LOAD;
      ST_MUL:  state_d = (op_q == OP_LD) ? ST_FIN : ST_LOAD;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_HUE;
      cnt_q        <= '0;
      max_level_q  <= 7'd100;
      lights_off_q <= 1'b0;
      hue_q        <= '0;
      sat_q        <= '0;
      val_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_MAX_LEVEL)  max_level_q  <= cfg_data_i;
        if (cfg_index_i == REG_LIGHTS_OFF) lights_off_q <= cfg_data_i[0];
      end
      if (in_xfer) begin
        op_q <= (in_data_i.command == CMD_RGB) ? OP_HUE : OP_RV;
        if (in_data_i.command == CMD_HSV) begin
          hue_q <= (in_data_i.hue_in > 9'd359) ? 9'd359 : in_data_i.hue_in;
          sat_q <= (in_data_i.sat_in > 7'd100) ? 7'd100 : in_data_i.sat_in;
          val_q <= (in_data_i.val_in > 7'd100) ? 7'd100 : in_data_i.val_in;
        end
      end
      if (state_q == ST_LOAD) cnt_q <= 5'(DvdW - 1);
      else if (state_q == ST_DIV) cnt_q <= cnt_q - 5'd1;
      if ((div_last || mul_step) && (op_q != OP_LD)) op_q <= op_q + 4'd1;
      if (div_last) begin
        case (op_q)
          OP_HUE:  hue_q <= hue_fix;
          OP_SAT:  sat_q <= (mx == 8'd0) ? 7'd0 : (7'd100 - quo[6:0]);
          default: ;
        endcase
      end
      if (mul_step && (op_q == OP_VAL)) val_q <= rq[6:0];
      if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      r_q <= in_data_i.red_in;
      g_q <= in_data_i.green_in;
      b_q <= in_data_i.blue_in;
    end
    if (state_q == ST_LOAD) begin
      dvd_q <= ld_dvd;
      dsr_q <= ld_dsr;
      rem_q <= '0;
      mul_q <= ld_mul;
    end else if (state_q == ST_DIV) begin
      dvd_q <= quo;
      rem_q <= rem_next;
    end
    if (mul_step) begin
      case (op_q)
        OP_RV:   v_q    <= rq[6:0];
        OP_RM:   m_q    <= rq[6:0];
        OP_LV:   lvv_q  <= rq;
        OP_LM:   lmin_q <= rq;
        OP_LI:   linc_q <= rq;
        OP_LD:   ldec_q <= rq;
        default: ;
      endcase
    end
    if (state_q == ST_FIN && out_free) begin
      out_q.drive_red   <= lights_off_q ? 8'd255 : (8'd255 - lr);
      out_q.drive_green <= lights_off_q ? 8'd255 : (8'd255 - lg);
      out_q.drive_blue  <= lights_off_q ? 8'd255 : (8'd255 - lb);
      out_q.hue_out     <= hue_q;
      out_q.sat_out     <= sat_q;
      out_q.val_out     <= val_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/rhl_color_checker.sv
// Checker for the RGB/HSV LED color driver: predicts each result from accepted
// input transfers and compares it with the output transfers. Depends on rhl_pkg.
module rhl_color_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  rhl_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  rhl_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [6:0]    cfg_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  import rhl_pkg::*;

  logic [6:0] level_limit;
  logic       dark;
  logic [8:0] hue_q;
  logic [6:0] sat_q, val_q;
  out_t       color_queue[$];

  function automatic int trunc_div(int num, int den);
    if (num < 0) return -((-num) / den);
    return num / den;
  endfunction

  task automatic apply_command(input in_t it);
    int r, g, b, mx, mn, d, h, v, s, sector, f, m, lvv, lmin, linc, ldec;
    int lv[3];
    out_t o;
    if (it.command == CMD_RGB) begin
      r = int'(it.red_in); g = int'(it.green_in); b = int'(it.blue_in);
      mx = r; mn = r; h = 0;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (mx != mn) begin
        d = mx - mn;
        if (mx == r) h = trunc_div(60 * (g - b), d) + (g >= b ? 0 : 360);
        else if (mx == g) h = trunc_div(60 * (b - r), d) + 120;
        else h = trunc_div(60 * (r - g), d) + 240;
      end
      if (h >= 360) h -= 360;
      if (h < 0) h = 0;
      hue_q = 9'(h);
      sat_q = 7'((mx == 0) ? 0 : 100 - (100 * mn) / mx);
      val_q = 7'((100 * mx) / 255);
    end else if (it.command == CMD_HSV) begin
      hue_q = (it.hue_in > 9'd359) ? 9'd359 : it.hue_in;
      sat_q = (it.sat_in > 7'd100) ? 7'd100 : it.sat_in;
      val_q = (it.val_in > 7'd100) ? 7'd100 : it.val_in;
    end
    v = int'(val_q) * ((level_limit > 7'd100) ? 100 : int'(level_limit)) / 100;
    s = int'(sat_q); sector = (int'(hue_q) / 60) % 6; f = int'(hue_q) % 60;
    m = (100 - s) * v / 100;
    lvv = v * 255 / 100;
    lmin = m * 255 / 100;
    linc = (60 * m + (v - m) * f) * 255 / 6000;
    ldec = (60 * v - (v - m) * f) * 255 / 6000;
    case (sector)
      0: begin lv[0] = lvv;  lv[1] = linc; lv[2] = lmin; end
      1: begin lv[0] = ldec; lv[1] = lvv;  lv[2] = lmin; end
      2: begin lv[0] = lmin; lv[1] = lvv;  lv[2] = linc; end
      3: begin lv[0] = lmin; lv[1] = ldec; lv[2] = lvv;  end
      4: begin lv[0] = linc; lv[1] = lmin; lv[2] = lvv;  end
      default: begin lv[0] = lvv; lv[1] = lmin; lv[2] = ldec; end
    endcase
    o.drive_red   = dark ? 8'd255 : 8'(255 - lv[0]);
    o.drive_green = dark ? 8'd255 : 8'(255 - lv[1]);
    o.drive_blue  = dark ? 8'd255 : 8'(255 - lv[2]);
    o.hue_out = hue_q; o.sat_out = sat_q; o.val_out = val_q;
    color_queue.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      level_limit <= 7'd100; dark <= 1'b0;
      hue_q = '0; sat_q = '0; val_q = '0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_MAX_LEVEL) level_limit <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == REG_LIGHTS_OFF) dark <= cfg_data_i[0];
      if (out_valid_i && !out_stall_i) begin
        if (color_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = color_queue.pop_front();
          if (want !== out_data_i) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_command(in_data_i);
    end
  end

  assign pending_o = color_queue.size();
endmodule

// File: test/tb_rgb_hsv_led_color_driver.sv
// Testbench top for the RGB/HSV LED color driver: clock, reset, stimulus,
// config phases and verdict. Depends on rhl_pkg, rgb_hsv_led_color_driver and rhl_color_checker.
module tb_rgb_hsv_led_color_driver;
  import rhl_pkg::*;

  localparam int DrainCycles = 260;     // longer than the slowest item latency
  localparam int WatchdogLimit = 20000; // cycles with no transfer on any channel

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t  in_data_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [6:0] cfg_data_i;
  int   fail_count, pending, sent;
  int   idle_cycles = 0;

  rgb_hsv_led_color_driver DUT (.*);

  rhl_color_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Short gaps mostly, an occasional long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Receiver stall: random on/off, with a quiet stretch in the middle of the run.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      if (sent > 500 && sent < 650) n = 0;
      repeat (n) @(posedge clk_i) out_stall_i <= 1'b1;
      @(posedge clk_i) out_stall_i <= 1'b0;
    end
  end

  // Watchdog: a long run of cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Valid stays high after a transfer when the next item follows at once.
  task automatic send_item(input in_t it, input bit with_gaps);
    int n;
    n = with_gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_cmd(input logic [1:0] c, input int r, g, b, h, s, v);
    in_t it;
    it.command = c; it.red_in = 8'(r); it.green_in = 8'(g); it.blue_in = 8'(b);
    it.hue_in = 9'(h); it.sat_in = 7'(s); it.val_in = 7'(v);
    send_item(it, 1'b0);
  endtask

  // Wait for all results, then let the block settle before a register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after its last write.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Random transfer: mostly legal RGB/HSV commands, some out-of-range fields, some re-apply and unused command codes.
  task automatic send_random();
    in_t         it;
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    it = raw[$bits(in_t)-1:0];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.command = CMD_RGB;
      4, 5, 6: begin
        it.command = CMD_HSV;
        it.hue_in = 9'($urandom_range(0, 359));
        it.sat_in = 7'($urandom_range(0, 100));
        it.val_in = 7'($urandom_range(0, 100));
      end
      7: it.command = CMD_HSV;      // any field value, saturation paths
      default: it.command = ($urandom_range(0, 1) == 0) ? CMD_REAPPLY : CMD_SPARE;
    endcase
    send_item(it, 1'b1);
  endtask

  initial begin
    logic [6:0] levels[6];
    levels = '{7'd100, 7'd0, 7'd127, 7'd50, 7'd1, 7'd99};
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every command, red tie, hue wrap from 360 to 0,
    // out-of-range HSV, unused command code.
    send_cmd(CMD_REAPPLY, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_RGB, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_RGB, 255, 255, 255, 0, 0, 0);
    send_cmd(CMD_RGB, 255, 0, 0, 0, 0, 0);
    send_cmd(CMD_RGB, 0, 255, 0, 0, 0, 0);
    send_cmd(CMD_RGB, 0, 0, 255, 0, 0, 0);
    send_cmd(CMD_RGB, 255, 255, 0, 0, 0, 0);
    send_cmd(CMD_RGB, 255, 0, 255, 0, 0, 0);
    send_cmd(CMD_RGB, 0, 255, 255, 0, 0, 0);
    send_cmd(CMD_RGB, 255, 0, 1, 0, 0, 0);
    send_cmd(CMD_RGB, 200, 17, 18, 0, 0, 0);
    send_cmd(CMD_HSV, 0, 0, 0, 0, 100, 100);
    send_cmd(CMD_HSV, 0, 0, 0, 359, 100, 100);
    send_cmd(CMD_HSV, 0, 0, 0, 511, 127, 127);
    send_cmd(CMD_HSV, 0, 0, 0, 360, 101, 101);
    send_cmd(CMD_HSV, 0, 0, 0, 59, 0, 100);
    send_cmd(CMD_HSV, 0, 0, 0, 180, 50, 0);
    send_cmd(CMD_SPARE, 255, 255, 255, 511, 127, 127);
    send_cmd(CMD_REAPPLY, 0, 0, 0, 0, 0, 0);

    // Random phases across brightness settings and the lights-off register.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_MAX_LEVEL, levels[ph]);
      write_reg(REG_LIGHTS_OFF, (ph == 2 || ph == 4) ? 7'd1 : 7'd0);
      write_reg(REG_SPARE, 7'd5);  // unknown index, ignored
      cfg_we_i <= 1'b0;
      for (int k = 0; k < 180; k++) send_random();
    end

    drain();
    $display("Ran %0d transfers over six brightness/lights-off settings,", sent);
    $display("with directed extremes and random stalls on both channels.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
